@@ hdl/kwsm_pkg.sv @@
package kwsm_pkg;

   localparam int MAX_WAYS     = 8;
   localparam int BUFFER_DEPTH = 8;
   localparam int KEY_BITS     = 32;
   localparam int CFG_BITS     = 4;
   localparam int CFG_RESET    = 8;
   localparam int WAY_BITS     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAYN_BITS    = $clog2(MAX_WAYS + 1);
   localparam int PTR_BITS     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int COUNT_BITS   = $clog2(BUFFER_DEPTH + 1);
   localparam int MEM_DEPTH    = MAX_WAYS * BUFFER_DEPTH;
   localparam int ADDR_BITS    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   typedef struct packed {
      logic load_input;
      logic scan_start;
      logic scan_step;
      logic pop;
      logic head_load;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic can_emit;
      logic all_done;
      logic scan_last;
      logic last;
   } ctrl_status_type;

endpackage

@@ hdl/kwsm_ctrl.sv @@
module kwsm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  kwsm_pkg::ctrl_status_type status,
   output kwsm_pkg::ctrl_cmd_type    cmd
);
   import kwsm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EVAL = 6'b000010,
      S_SCAN = 6'b000100,
      S_POP  = 6'b001000,
      S_HEAD = 6'b010000,
      S_EMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_input = 1'b1;
               state_in       = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.can_emit) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               cmd.clear = status.all_done;
               state_in  = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.head_load = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/kwsm_datapath.sv @@
module kwsm_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [kwsm_pkg::CFG_BITS-1:0]         csr_write_data,
   input  logic [kwsm_pkg::WAY_BITS-1:0]         req_way,
   input  logic                                  req_has_key,
   input  logic signed [kwsm_pkg::KEY_BITS-1:0]  req_key,
   input  logic                                  req_way_end,
   input  kwsm_pkg::ctrl_cmd_type                cmd,
   output kwsm_pkg::ctrl_status_type             status,
   output logic signed [kwsm_pkg::KEY_BITS-1:0]  rsp_merged_key,
   output logic [kwsm_pkg::WAY_BITS-1:0]         rsp_source_way,
   output logic                                  rsp_last_of_merge,
   output logic                                  rsp_dropped
);
   import kwsm_pkg::*;

   logic [CFG_BITS-1:0]         ways_ff, ways_in;
   logic [COUNT_BITS-1:0]       count_ff [MAX_WAYS];
   logic [COUNT_BITS-1:0]       count_in [MAX_WAYS];
   logic [PTR_BITS-1:0]         rptr_ff [MAX_WAYS];
   logic [PTR_BITS-1:0]         rptr_in [MAX_WAYS];
   logic [MAX_WAYS-1:0]         fin_ff, fin_in;
   logic signed [KEY_BITS-1:0]  head_ff [MAX_WAYS];
   logic signed [KEY_BITS-1:0]  head_in [MAX_WAYS];
   logic                        drop_ff, drop_in;
   logic [WAY_BITS-1:0]         idx_ff, idx_in;
   logic [WAY_BITS-1:0]         best_ff, best_in;
   logic signed [KEY_BITS-1:0]  best_key_ff, best_key_in;
   logic                        found_ff, found_in;
   logic signed [KEY_BITS-1:0]  out_key_ff, out_key_in;
   logic [WAY_BITS-1:0]         out_way_ff, out_way_in;
   logic                        out_last_ff, out_last_in;
   logic                        out_drop_ff, out_drop_in;
   logic signed [KEY_BITS-1:0]  mem [MEM_DEPTH];
   logic signed [KEY_BITS-1:0]  rd_data_ff;

   logic [WAYN_BITS-1:0]        n_ways;
   logic                        in_use;
   logic                        mem_we;
   logic [ADDR_BITS-1:0]        wr_addr;
   logic [ADDR_BITS-1:0]        rd_addr;
   logic [COUNT_BITS:0]         slot_sum;
   logic [PTR_BITS-1:0]         slot;
   logic [PTR_BITS-1:0]         rptr_next;
   logic                        can_emit;
   logic                        all_done;
   logic                        blocked;
   logic                        any_head;

   always_comb begin
      if (ways_ff == '0) begin
         n_ways = WAYN_BITS'(1);
      end else if (32'(ways_ff) > MAX_WAYS) begin
         n_ways = WAYN_BITS'(MAX_WAYS);
      end else begin
         n_ways = WAYN_BITS'(ways_ff);
      end
   end

   always_comb begin
      any_head = 1'b0;
      blocked  = 1'b0;
      all_done = 1'b1;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w < 32'(n_ways)) begin
            if (count_ff[w] != '0) begin
               any_head = 1'b1;
               all_done = 1'b0;
            end else if (!fin_ff[w]) begin
               blocked  = 1'b1;
               all_done = 1'b0;
            end
         end
      end
      can_emit = any_head && !blocked;
   end

   assign in_use   = 32'(req_way) < 32'(n_ways);
   assign slot_sum = (COUNT_BITS + 1)'(rptr_ff[req_way]) + (COUNT_BITS + 1)'(count_ff[req_way]);
   assign slot     = (32'(slot_sum) >= BUFFER_DEPTH)
                   ? PTR_BITS'(32'(slot_sum) - BUFFER_DEPTH) : PTR_BITS'(slot_sum);
   assign wr_addr  = ADDR_BITS'(ADDR_BITS'(req_way) * ADDR_BITS'(BUFFER_DEPTH))
                   + ADDR_BITS'(slot);
   assign rptr_next = (32'(rptr_ff[best_ff]) == BUFFER_DEPTH - 1)
                    ? '0 : PTR_BITS'(rptr_ff[best_ff] + 1'b1);
   assign rd_addr  = ADDR_BITS'(ADDR_BITS'(best_ff) * ADDR_BITS'(BUFFER_DEPTH))
                   + ADDR_BITS'(rptr_next);
   assign mem_we   = cmd.load_input && in_use && req_has_key && !fin_ff[req_way]
                   && (32'(count_ff[req_way]) < BUFFER_DEPTH);

   always_comb begin
      ways_in     = ways_ff;
      count_in    = count_ff;
      rptr_in     = rptr_ff;
      fin_in      = fin_ff;
      head_in     = head_ff;
      drop_in     = drop_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_key_in = best_key_ff;
      found_in    = found_ff;
      out_key_in  = out_key_ff;
      out_way_in  = out_way_ff;
      out_last_in = out_last_ff;
      out_drop_in = out_drop_ff;

      if (csr_write_enable) begin
         ways_in = csr_write_data;
      end

      if (cmd.load_input && in_use) begin
         if (req_has_key && !fin_ff[req_way]) begin
            if (32'(count_ff[req_way]) >= BUFFER_DEPTH) begin
               drop_in = 1'b1;
            end else begin
               if (count_ff[req_way] == '0) begin
                  head_in[req_way] = req_key;
               end
               count_in[req_way] = count_ff[req_way] + 1'b1;
            end
         end
         if (req_way_end) begin
            fin_in[req_way] = 1'b1;
         end
      end

      if (cmd.scan_start) begin
         idx_in   = '0;
         found_in = 1'b0;
      end

      if (cmd.scan_step) begin
         if (32'(idx_ff) < 32'(n_ways) && count_ff[idx_ff] != '0
             && (!found_ff || head_ff[idx_ff] < best_key_ff)) begin
            best_in     = idx_ff;
            best_key_in = head_ff[idx_ff];
            found_in    = 1'b1;
         end
         idx_in = WAY_BITS'(idx_ff + 1'b1);
      end

      if (cmd.pop) begin
         count_in[best_ff] = count_ff[best_ff] - 1'b1;
         rptr_in[best_ff]  = rptr_next;
      end

      if (cmd.head_load) begin
         if (count_ff[best_ff] != '0) begin
            head_in[best_ff] = rd_data_ff;
         end
         out_key_in  = best_key_ff;
         out_way_in  = best_ff;
         out_last_in = all_done;
         out_drop_in = drop_ff;
      end

      if (cmd.clear) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            count_in[w] = '0;
            rptr_in[w]  = '0;
         end
         fin_in  = '0;
         drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= CFG_BITS'(CFG_RESET);
         for (int w = 0; w < MAX_WAYS; w++) begin
            count_ff[w] <= '0;
            rptr_ff[w]  <= '0;
         end
         fin_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         ways_ff  <= ways_in;
         count_ff <= count_in;
         rptr_ff  <= rptr_in;
         fin_ff   <= fin_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_key_ff <= best_key_in;
      found_ff    <= found_in;
      out_key_ff  <= out_key_in;
      out_way_ff  <= out_way_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_key;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign status.can_emit  = can_emit;
   assign status.all_done  = all_done;
   assign status.scan_last = (32'(idx_ff) == MAX_WAYS - 1);
   assign status.last      = out_last_ff;

   assign rsp_merged_key    = out_key_ff;
   assign rsp_source_way    = out_way_ff;
   assign rsp_last_of_merge = out_last_ff;
   assign rsp_dropped       = out_drop_ff;

endmodule

@@ hdl/k_way_sorted_merge_unit.sv @@
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   way, has_key, key, way_end
// rsp_      out        rsp_valid/rsp_stall   merged_key, source_way, last_of_merge, dropped
// csr_      in         csr_write_enable      ways_in_use
//
// An input beat that causes no result passes through the evaluate state and returns to idle.
// Each result passes through the evaluate, scan, pop, head-load and emit states; the scan visits
// every way head, also those not in use, and after the result that ends a merge the unit returns to idle.
// Reset is synchronous and clears the merge state; ways_in_use returns to eight.
// A stalled result holds, and no input beat is taken until all its results have gone.
module k_way_sorted_merge_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [kwsm_pkg::CFG_BITS-1:0]         csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [kwsm_pkg::WAY_BITS-1:0]         req_way,
   input  logic                                  req_has_key,
   input  logic signed [kwsm_pkg::KEY_BITS-1:0]  req_key,
   input  logic                                  req_way_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [kwsm_pkg::KEY_BITS-1:0]  rsp_merged_key,
   output logic [kwsm_pkg::WAY_BITS-1:0]         rsp_source_way,
   output logic                                  rsp_last_of_merge,
   output logic                                  rsp_dropped
);
   import kwsm_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   kwsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   kwsm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_way           (req_way),
      .req_has_key       (req_has_key),
      .req_key           (req_key),
      .req_way_end       (req_way_end),
      .cmd               (cmd),
      .status            (status),
      .rsp_merged_key    (rsp_merged_key),
      .rsp_source_way    (rsp_source_way),
      .rsp_last_of_merge (rsp_last_of_merge),
      .rsp_dropped       (rsp_dropped)
   );

endmodule
